[sv/cda_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar date-time adder package
// Shared types, constants and calendar helper functions.
// ----------------------------------------------------------------------------
package cda_pkg;

   // Number of month-walk stages. Each stage rolls the day over at most one month.
   localparam int DAY_STEPS = 12;

   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Years (offset from 2000) that are divisible by 100 but not by 400.
   localparam logic [7:0] YEAR_2100 = 8'd100;
   localparam logic [7:0] YEAR_2200 = 8'd200;

   // Reciprocal of 12 for quotients of values below 270.
   localparam logic [9:0] RECIP12      = 10'd683;
   localparam int         RECIP12_SHIFT = 13;

   // Front-end word: time-of-day sums that are still being carried.
   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [8:0] day;
      logic [8:0] hour;
      logic [8:0] minute;
      logic [5:0] second;
      logic [7:0] add_years;
      logic [7:0] add_months;
      logic [7:0] add_days;
      logic [7:0] add_hours;
   } cda_front_type;

   // Day-walk word: time of day is final, the day still rolls over months.
   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [8:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [7:0] add_years;
      logic [7:0] add_months;
   } cda_item_type;

   // Days in a month; months outside 1..12 count as 31 days.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic [7:0] year);
      logic leap;
      leap = (year[1:0] == 2'd0) && (year != YEAR_2100) && (year != YEAR_2200);
      unique case (month)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = 5'd30;
         MONTH_FEB: month_len = leap ? 5'd29 : 5'd28;
         default:   month_len = 5'd31;
      endcase
   endfunction

   // Quotient by 60 for values up to 323.
   function automatic logic [2:0] quot60(input logic [8:0] v);
      logic [2:0] q;
      q = '0;
      for (int k = 1; k <= 5; k++) begin
         if (v >= 9'(k * 60)) q = 3'(k);
      end
      return q;
   endfunction

   // Quotient by 24 for values up to 291.
   function automatic logic [3:0] quot24(input logic [8:0] v);
      logic [3:0] q;
      q = '0;
      for (int k = 1; k <= 12; k++) begin
         if (v >= 9'(k * 24)) q = 4'(k);
      end
      return q;
   endfunction

endpackage

[sv/cda_day_step.sv]
// ----------------------------------------------------------------------------
// Day-walk stage
// Rolls the day sum over one month if it exceeds that month's length.
// ----------------------------------------------------------------------------
module cda_day_step
   import cda_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  cda_item_type in_item,
   output logic         out_valid,
   output cda_item_type out_item
);

   logic         valid_ff;
   cda_item_type item_ff;
   cda_item_type item_in;
   logic [4:0]   len;

   // Step one month forward when the day does not fit.
   always_comb begin
      item_in = in_item;
      len     = month_len(in_item.month, in_item.year);
      if (in_item.day > 9'(len)) begin
         item_in.day = in_item.day - 9'(len);
         if (in_item.month >= MONTH_DEC) begin
            item_in.month = in_item.month - 4'd11;
            item_in.year  = in_item.year + 8'd1;
         end else begin
            item_in.month = in_item.month + 4'd1;
         end
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/calendar_datetime_adder_unit.sv]
// ----------------------------------------------------------------------------
// Calendar date-time adder
// Adds years, months, days, hours, minutes and seconds to a Gregorian
// date-time, carrying smallest unit first.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input word passes 3 time-carry stages, 12 month-walk
// stages and 3 month/year stages on its way to its result word.
// Throughput: one word per cycle; the whole pipeline holds while the
// output word is stalled.
// Reset: synchronous, clears all valid bits; data registers are not reset.
module calendar_datetime_adder_unit
   import cda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second, add_years,
   // add_months, add_days, add_hours, add_minutes, add_seconds, zero fill
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_year, new_month, new_day, new_hour, new_minute, new_second, zero fill
   output logic [39:0] rsp_tdata
);

   logic advance;

   // Input fields.
   logic [7:0] cur_year, add_years, add_months, add_days, add_hours;
   logic [7:0] add_minutes, add_seconds;
   logic [3:0] cur_month;
   logic [4:0] cur_day, cur_hour;
   logic [5:0] cur_minute, cur_second;

   assign cur_year    = req_tdata[7:0];
   assign cur_month   = req_tdata[11:8];
   assign cur_day     = req_tdata[16:12];
   assign cur_hour    = req_tdata[21:17];
   assign cur_minute  = req_tdata[27:22];
   assign cur_second  = req_tdata[33:28];
   assign add_years   = req_tdata[41:34];
   assign add_months  = req_tdata[49:42];
   assign add_days    = req_tdata[57:50];
   assign add_hours   = req_tdata[65:58];
   assign add_minutes = req_tdata[73:66];
   assign add_seconds = req_tdata[81:74];

   // The whole pipeline moves unless the output word is held.
   logic out_valid_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Stage 1: seconds carry into minutes.
   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   cda_front_type s1_ff, s1_in, s2_ff, s2_in;
   cda_item_type  s3_ff, s3_in;
   logic [8:0]    sec_sum;
   logic [2:0]    sec_q;
   logic [2:0]    min_q;
   logic [3:0]    hour_q;

   always_comb begin
      sec_sum          = 9'(cur_second) + 9'(add_seconds);
      sec_q            = quot60(sec_sum);
      s1_in.year       = cur_year;
      s1_in.month      = cur_month;
      s1_in.day        = 9'(cur_day);
      s1_in.hour       = 9'(cur_hour);
      s1_in.minute     = 9'(cur_minute) + 9'(add_minutes) + 9'(sec_q);
      s1_in.second     = 6'(sec_sum - 9'(sec_q) * 9'd60);
      s1_in.add_years  = add_years;
      s1_in.add_months = add_months;
      s1_in.add_days   = add_days;
      s1_in.add_hours  = add_hours;
   end

   // Stage 2: minutes carry into hours.
   always_comb begin
      s2_in        = s1_ff;
      min_q        = quot60(s1_ff.minute);
      s2_in.minute = s1_ff.minute - 9'(min_q) * 9'd60;
      s2_in.hour   = s1_ff.hour + 9'(s1_ff.add_hours) + 9'(min_q);
   end

   // Stage 3: hours carry into days.
   always_comb begin
      hour_q           = quot24(s2_ff.hour);
      s3_in.year       = s2_ff.year;
      s3_in.month      = s2_ff.month;
      s3_in.day        = s2_ff.day + 9'(s2_ff.add_days) + 9'(hour_q);
      s3_in.hour       = 5'(s2_ff.hour - 9'(hour_q) * 9'd24);
      s3_in.minute     = 6'(s2_ff.minute);
      s3_in.second     = s2_ff.second;
      s3_in.add_years  = s2_ff.add_years;
      s3_in.add_months = s2_ff.add_months;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   // Month walk: one stage per month that the day may roll over.
   logic         walk_valid [DAY_STEPS+1];
   cda_item_type walk_item  [DAY_STEPS+1];

   assign walk_valid[0] = s3_valid_ff;
   assign walk_item[0]  = s3_ff;

   for (genvar g = 0; g < DAY_STEPS; g++) begin : g_walk
      cda_day_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (walk_valid[g]),
         .in_item   (walk_item[g]),
         .out_valid (walk_valid[g+1]),
         .out_item  (walk_item[g+1])
      );
   end

   // Month stage 1: add the months.
   logic         m1_valid_ff, m2_valid_ff;
   cda_item_type m1_item_ff, m2_item_ff;
   logic [8:0]   m1_sum_ff, m1_sum_in;
   logic [8:0]   m2_sum_ff;
   logic [8:0]   m2_x_ff, m2_x_in;
   logic [4:0]   m2_q_ff, m2_q_in;
   logic [17:0]  m2_prod;
   cda_item_type fin_item;

   assign m1_sum_in = 9'(walk_item[DAY_STEPS].month) + 9'(walk_item[DAY_STEPS].add_months);

   // Month stage 2: quotient of (month - 1) by 12 through the reciprocal.
   always_comb begin
      m2_x_in = m1_sum_ff - 9'd1;
      m2_prod = 18'(m2_x_in) * 18'(RECIP12);
      m2_q_in = m2_prod[RECIP12_SHIFT +: 5];
   end

   // Month stage 3: fold the month and add the years.
   always_comb begin
      fin_item = m2_item_ff;
      if (m2_sum_ff > 9'(MONTH_DEC)) begin
         fin_item.month = 4'(m2_x_ff - 9'(m2_q_ff) * 9'd12 + 9'd1);
         fin_item.year  = m2_item_ff.year + 8'(m2_q_ff) + m2_item_ff.add_years;
      end else begin
         fin_item.month = m2_sum_ff[3:0];
         fin_item.year  = m2_item_ff.year + m2_item_ff.add_years;
      end
   end

   logic [39:0] out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff  <= walk_valid[DAY_STEPS];
         m2_valid_ff  <= m1_valid_ff;
         out_valid_ff <= m2_valid_ff;
      end
      if (advance) begin
         m1_item_ff  <= walk_item[DAY_STEPS];
         m1_sum_ff   <= m1_sum_in;
         m2_item_ff  <= m1_item_ff;
         m2_sum_ff   <= m1_sum_ff;
         m2_x_ff     <= m2_x_in;
         m2_q_ff     <= m2_q_in;
         out_data_ff <= {6'd0, fin_item.second, fin_item.minute, fin_item.hour,
                         fin_item.day[4:0], fin_item.month, fin_item.year};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[sv/cda_checker.sv]
// ----------------------------------------------------------------------------
// Calendar date-time adder port checker
// Watches the result channel for handshake and range errors, and the input ready.
// ----------------------------------------------------------------------------
module cda_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A stalled result word holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Seconds and minutes are always fully carried.
   a_sec_min: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:28] < 6'd60) && (rsp_tdata[27:22] < 6'd60))
      else $error("second or minute out of range");

   // Hours are always fully carried.
   a_hour: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[21:17] < 5'd24)
      else $error("hour out of range");

   // Months are always folded into a year.
   a_month: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:8] <= 4'd12)
      else $error("month out of range");

   // The input side is never held while the output side is free.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled with free output");

endmodule

bind calendar_datetime_adder_unit cda_checker u_cda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/tb_calendar_datetime_adder_unit.sv]
// ----------------------------------------------------------------------------
// Calendar date-time adder testbench
// Drives date-time plus amount words with random gaps on both sides and
// checks every result word against a table entry or a behavioral calendar adder.
// ----------------------------------------------------------------------------
module tb_calendar_datetime_adder_unit;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [7:0] add_seconds;
      logic [7:0] add_minutes;
      logic [7:0] add_hours;
      logic [7:0] add_days;
      logic [7:0] add_months;
      logic [7:0] add_years;
      logic [5:0] cur_second;
      logic [5:0] cur_minute;
      logic [4:0] cur_hour;
      logic [4:0] cur_day;
      logic [3:0] cur_month;
      logic [7:0] cur_year;
   } date_sum_type;

   typedef struct packed {
      logic [5:0] new_second;
      logic [5:0] new_minute;
      logic [4:0] new_hour;
      logic [4:0] new_day;
      logic [3:0] new_month;
      logic [7:0] new_year;
   } date_out_type;

   typedef struct {
      date_sum_type din;
      bit           typed;
      date_out_type dout;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   date_out_type expected_dates[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   bit           stim_done = 1'b0;

   calendar_datetime_adder_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Days in a month, Gregorian leap rule; out-of-range months are 31 long.
   function automatic int unsigned days_in_month(int unsigned mon, int unsigned yr);
      int unsigned full;
      full = (yr & 8'hFF) + 2000;
      if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
      if (mon == 2) return ((full % 4 == 0 && full % 100 != 0) || full % 400 == 0) ? 29 : 28;
      return 31;
   endfunction

   // Adds the amount to the date-time, smallest unit first.
   function automatic date_out_type add_datetime(date_sum_type d);
      int unsigned yr, mon, dy, hr, mi, se, len;
      date_out_type r;
      yr = d.cur_year; mon = d.cur_month; dy = d.cur_day;
      hr = d.cur_hour; mi = d.cur_minute; se = d.cur_second;
      se += d.add_seconds;
      mi += d.add_minutes + se / 60; se %= 60;
      hr += d.add_hours + mi / 60;   mi %= 60;
      dy += d.add_days + hr / 24;    hr %= 24;
      len = days_in_month(mon, yr);
      while (dy > len) begin
         dy -= len;
         mon++;
         if (mon > 12) begin
            mon -= 12;
            yr = (yr + 1) & 8'hFF;
         end
         len = days_in_month(mon, yr);
      end
      mon += d.add_months;
      if (mon > 12) begin
         yr += (mon - 1) / 12;
         mon = (mon - 1) % 12 + 1;
      end
      yr = (yr + d.add_years) & 8'hFF;
      r.new_year = yr[7:0]; r.new_month = mon[3:0]; r.new_day = dy[4:0];
      r.new_hour = hr[4:0]; r.new_minute = mi[5:0]; r.new_second = se[5:0];
      return r;
   endfunction

   function automatic date_sum_type make_sum(int yr, int mon, int dy, int hr, int mi, int se,
                                             int ayr, int amo, int ady, int ahr, int ami,
                                             int ase);
      date_sum_type d;
      d.cur_year = 8'(yr); d.cur_month = 4'(mon); d.cur_day = 5'(dy); d.cur_hour = 5'(hr);
      d.cur_minute = 6'(mi); d.cur_second = 6'(se); d.add_years = 8'(ayr);
      d.add_months = 8'(amo); d.add_days = 8'(ady); d.add_hours = 8'(ahr);
      d.add_minutes = 8'(ami); d.add_seconds = 8'(ase);
      return d;
   endfunction

   // Mostly valid dates; now and then any value the field widths allow.
   function automatic date_sum_type random_sum();
      date_sum_type d;
      d = date_sum_type'(88'({$urandom, $urandom, $urandom}));
      if ($urandom_range(0, 9) != 0) begin
         d.cur_month  = 4'($urandom_range(1, 12));
         d.cur_day    = 5'($urandom_range(1, days_in_month(d.cur_month, d.cur_year)));
         d.cur_hour   = 5'($urandom_range(0, 23));
         d.cur_minute = 6'($urandom_range(0, 59));
         d.cur_second = 6'($urandom_range(0, 59));
      end
      return d;
   endfunction

   // Sends one word after a random gap and records its expected result.
   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(date_sum_type d, bit typed, date_out_type dout);
      int gap;
      gap = $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= 88'(d);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_dates.push_back(typed ? dout : add_datetime(d));
      @(negedge clock);
   endtask

   // Stimulus: directed table, then random words.
   initial begin
      table_row_type rows[$];
      date_out_type  none;
      none = '0;
      rows.push_back('{make_sum(0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       date_out_type'({6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 8'd0})});
      rows.push_back('{make_sum(255, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0, 1), 1,
                       date_out_type'({6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 8'd0})});
      rows.push_back('{make_sum(255, 12, 31, 23, 59, 59, 255, 255, 255, 255, 255, 255), 0, none});
      rows.push_back('{make_sum(0, 2, 28, 23, 59, 59, 0, 0, 0, 0, 0, 1), 0, none});
      rows.push_back('{make_sum(100, 2, 28, 23, 59, 59, 0, 0, 0, 0, 0, 1), 0, none});
      rows.push_back('{make_sum(200, 2, 28, 0, 0, 0, 0, 0, 1, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(4, 2, 29, 0, 0, 0, 0, 12, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(1, 1, 31, 0, 0, 0, 0, 1, 0, 0, 0, 0), 0, none});
      // Time fields above range carry up like any excess.
      rows.push_back('{make_sum(3, 5, 10, 31, 63, 63, 0, 0, 0, 0, 0, 0), 0, none});
      // Months outside 1..12, including month zero with and without carry.
      rows.push_back('{make_sum(7, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(7, 0, 31, 0, 0, 0, 0, 0, 1, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(7, 15, 31, 0, 0, 0, 0, 0, 1, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(7, 13, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(7, 14, 5, 0, 0, 0, 0, 3, 0, 0, 0, 0), 0, none});
      // Day zero, days past the end of the month, then large amounts.
      rows.push_back('{make_sum(9, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(9, 4, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(9, 2, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_sum(0, 1, 1, 0, 0, 0, 0, 0, 255, 255, 0, 0), 0, none});
      rows.push_back('{make_sum(250, 11, 30, 12, 30, 30, 10, 200, 200, 100, 100, 100), 0, none});
      rows.push_back('{make_sum(31, 15, 31, 31, 63, 63, 255, 255, 255, 255, 255, 255), 0, none});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_word(rows[i].din, rows[i].typed, rows[i].dout);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Halfway through, hold off until the pipeline has drained.
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            wait (expected_dates.size() == 0);
            @(negedge clock);
         end
         send_word(random_sum(), 1'b0, none);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // Result side: random stalls, with a stall-free stretch in the middle.
   initial begin
      int stall;
      int taken;
      taken = 0;
      forever begin
         @(negedge clock);
         stall = (taken > 600 && taken < 800) ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // Compare each result word with the oldest expectation.
   always @(posedge clock) begin
      date_out_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = date_out_type'(rsp_tdata);
         if (expected_dates.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_dates.pop_front();
            if (got.new_year != want.new_year) begin
               $error("new_year expected %0d actual %0d", want.new_year, got.new_year);
               error_count++;
            end
            if (got.new_month != want.new_month) begin
               $error("new_month expected %0d actual %0d", want.new_month, got.new_month);
               error_count++;
            end
            if (got.new_day != want.new_day) begin
               $error("new_day expected %0d actual %0d", want.new_day, got.new_day);
               error_count++;
            end
            if (got.new_hour != want.new_hour) begin
               $error("new_hour expected %0d actual %0d", want.new_hour, got.new_hour);
               error_count++;
            end
            if (got.new_minute != want.new_minute) begin
               $error("new_minute expected %0d actual %0d", want.new_minute, got.new_minute);
               error_count++;
            end
            if (got.new_second != want.new_second) begin
               $error("new_second expected %0d actual %0d", want.new_second, got.new_second);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no word moving on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // End of run: drain, then keep watching for stray words before the verdict.
   initial begin
      wait (stim_done && expected_dates.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_dates.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[calendar_datetime_adder_unit.f]
sv/cda_pkg.sv
sv/cda_day_step.sv
sv/calendar_datetime_adder_unit.sv
sv/cda_checker.sv
tb/tb_calendar_datetime_adder_unit.sv
